FILE: rtl/core/cht_pkg.sv
// ----------------------------------------------------------------------------
// cht_pkg
// Shared types and constants for the two-table cuckoo hash set.
// ----------------------------------------------------------------------------
package cht_pkg;

  localparam int KEY_W          = 31;
  localparam int TABLE_SIZE_DEF = 8;

  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_ERASE  = 1'b1;

  typedef enum logic [1:0] {
    ST_INSERTED  = 2'd0,
    ST_OVERFLOW  = 2'd1,
    ST_ERASED    = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_t;

endpackage

FILE: rtl/core/cht_ram.sv
// ----------------------------------------------------------------------------
// cht_ram
// Generic single-clock RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module cht_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: rtl/core/cuckoo_hash_table.sv
// ----------------------------------------------------------------------------
// cuckoo_hash_table
// Two-table cuckoo hash set of 31-bit keys with insert and erase commands.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall) carries one beat per command: an
//   insert or an erase of one key. Output channel (out_valid / out_stall)
//   returns exactly one result beat per command, in order.
//   Table one is indexed by key mod TABLE_SIZE, table two by
//   (key div TABLE_SIZE) mod TABLE_SIZE. Each table is one RAM with a
//   registered read; an entry holds {valid, slot in the other
//   table, key}, so a displaced key never needs its hash recomputed.
//   An insert makes up to TABLE_SIZE placements, one placement per cycle,
//   tables alternating. For a TABLE_SIZE that is not a power of two, the
//   slot indexes come from a reciprocal multiply by the constant size,
//   computed in registered steps between accept and the table lookup.
//   One command is in flight at a time; the next is accepted as soon as the
//   current result sits in the output register, even if it is still stalled.
//   If the receiver stalls, the finished result holds the engine in its
//   final state until the output register frees up.
//   Reset: a clearing pass writes every entry of both tables empty, with
//   in_stall high throughout.
// ----------------------------------------------------------------------------
module cuckoo_hash_table
  import cht_pkg::*;
#(
  parameter int TABLE_SIZE = TABLE_SIZE_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic             command,
  input  logic [KEY_W-1:0] key,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [1:0]       status,
  output logic [KEY_W-1:0] dropped_key,
  output logic             hit_table
);

  localparam int SW     = $clog2(TABLE_SIZE);     // slot index width
  localparam int WORD_W = 1 + SW + KEY_W;         // {valid, other slot, key}
  localparam bit SIZE_POW2 = (TABLE_SIZE & (TABLE_SIZE - 1)) == 0;
  localparam logic [SW-1:0] LAST_SLOT = SW'(TABLE_SIZE - 1);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_HASH,
    S_LOOKUP,
    S_PLACE,
    S_ERASE,
    S_DONE
  } state_t;

  state_t           state;
  logic             cmd_r;
  logic [KEY_W-1:0] key_r;
  logic [KEY_W-1:0] hand;        // key currently being placed
  logic [SW-1:0]    hand_slot;   // its slot in the table being written
  logic [SW-1:0]    hand_other;  // its slot in the opposite table
  logic             side;        // 0: table one, 1: table two
  logic [SW-1:0]    placed;
  logic [SW-1:0]    clr_cnt;
  status_t          res_status;
  logic [KEY_W-1:0] res_dropped;
  logic             res_hit;
  status_t          out_status;

  logic              accept;
  logic              hash_done;
  logic [SW-1:0]     hash_s1;
  logic [SW-1:0]     hash_s2;

  // RAM ports
  logic              we1, we2, re1, re2;
  logic [SW-1:0]     wa1, wa2, ra1, ra2;
  logic [WORD_W-1:0] wd1, wd2, rd1, rd2;

  // placement datapath
  logic [WORD_W-1:0] cur_word;
  logic              cur_v;
  logic [SW-1:0]     cur_oth;
  logic [KEY_W-1:0]  cur_key;
  logic [WORD_W-1:0] new_word;
  logic              last_place;
  logic              hit1, hit2;

  assign in_stall = (state != S_IDLE);
  assign accept   = in_valid && !in_stall;

  // --------------------------------------------------------------------------
  // Slot hashing
  // --------------------------------------------------------------------------
  if (SIZE_POW2) begin : g_hash_mask
    assign hash_s1   = key_r[SW-1:0];
    assign hash_s2   = key_r[2*SW-1:SW];
    assign hash_done = 1'b1;
  end else begin : g_hash_recip
    // x div N = (x * MAGIC) >> (KEY_W + SW), exact for every 31-bit x.
    // Stage 0: q1 = key div N. Stage 1: slot one = key - q1*N, q2 = q1 div N.
    // Stage 2: slot two = q1 - q2*N. One shared reciprocal multiplier.
    localparam int PW = 2 * KEY_W + 1;
    localparam logic [63:0] MAGIC_WIDE =
      ((64'd1 << (KEY_W + SW)) / 64'(TABLE_SIZE)) + 64'd1;
    localparam logic [KEY_W:0]   MAGIC  = MAGIC_WIDE[KEY_W:0];
    localparam logic [KEY_W-1:0] SIZE_K = KEY_W'(TABLE_SIZE);

    logic             busy;
    logic [1:0]       stage;
    logic [KEY_W-1:0] q1;
    logic [KEY_W-1:0] q2;
    logic [SW-1:0]    s1;
    logic [SW-1:0]    s2;
    logic [KEY_W-1:0] mul_a;
    logic [PW-1:0]    prod;
    logic [KEY_W-1:0] quot;
    logic [KEY_W-1:0] sub_a;
    logic [KEY_W-1:0] sub_q;
    logic [KEY_W-1:0] rem_full;

    assign mul_a    = (stage == 2'd0) ? key_r : q1;
    assign prod     = PW'(mul_a) * PW'(MAGIC);
    assign quot     = KEY_W'(prod >> (KEY_W + SW));
    assign sub_a    = (stage == 2'd1) ? key_r : q1;
    assign sub_q    = (stage == 2'd1) ? q1 : q2;
    assign rem_full = sub_a - KEY_W'(sub_q * SIZE_K);

    always_ff @(posedge clk) begin
      if (rst) begin
        busy  <= 1'b0;
        stage <= 2'd0;
      end else if (accept) begin
        busy  <= 1'b1;
        stage <= 2'd0;
      end else if (busy) begin
        case (stage)
          2'd0: begin
            q1    <= quot;
            stage <= 2'd1;
          end
          2'd1: begin
            s1    <= SW'(rem_full);
            q2    <= quot;
            stage <= 2'd2;
          end
          default: begin
            s2   <= SW'(rem_full);
            busy <= 1'b0;
          end
        endcase
      end
    end

    assign hash_s1   = s1;
    assign hash_s2   = s2;
    assign hash_done = !busy;
  end

  // --------------------------------------------------------------------------
  // Tables
  // --------------------------------------------------------------------------
  cht_ram #(.WIDTH(WORD_W), .DEPTH(TABLE_SIZE)) u_tab1 (
    .clk   (clk),
    .we    (we1),
    .waddr (wa1),
    .wdata (wd1),
    .re    (re1),
    .raddr (ra1),
    .rdata (rd1)
  );

  cht_ram #(.WIDTH(WORD_W), .DEPTH(TABLE_SIZE)) u_tab2 (
    .clk   (clk),
    .we    (we2),
    .waddr (wa2),
    .wdata (wd2),
    .re    (re2),
    .raddr (ra2),
    .rdata (rd2)
  );

  assign cur_word   = side ? rd2 : rd1;
  assign cur_v      = cur_word[WORD_W-1];
  assign cur_oth    = cur_word[KEY_W +: SW];
  assign cur_key    = cur_word[KEY_W-1:0];
  assign new_word   = {1'b1, hand_other, hand};
  assign last_place = (placed == LAST_SLOT);
  assign hit1       = rd1[WORD_W-1] && (rd1[KEY_W-1:0] == key_r);
  assign hit2       = rd2[WORD_W-1] && (rd2[KEY_W-1:0] == key_r);

  // RAM port steering
  always_comb begin
    we1 = 1'b0;
    we2 = 1'b0;
    re1 = 1'b0;
    re2 = 1'b0;
    wa1 = hand_slot;
    wa2 = hand_slot;
    wd1 = new_word;
    wd2 = new_word;
    ra1 = hash_s1;
    ra2 = hash_s2;
    unique case (state)
      S_CLEAR: begin
        we1 = 1'b1;
        we2 = 1'b1;
        wa1 = clr_cnt;
        wa2 = clr_cnt;
        wd1 = '0;
        wd2 = '0;
      end
      S_LOOKUP: begin
        re1 = 1'b1;
        re2 = (cmd_r == CMD_ERASE);
      end
      S_PLACE: begin
        // write the hand into this table; fetch the evictee's other slot
        we1 = !side;
        we2 = side;
        re1 = side;
        re2 = !side;
        ra1 = cur_oth;
        ra2 = cur_oth;
      end
      S_ERASE: begin
        we1 = hit1;
        we2 = !hit1 && hit2;
        wa1 = hash_s1;
        wa2 = hash_s2;
        wd1 = '0;
        wd2 = '0;
      end
      S_IDLE, S_HASH, S_DONE: begin
      end
      default: begin
      end
    endcase
  end

  // --------------------------------------------------------------------------
  // Control
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_cnt   <= '0;
      out_valid <= 1'b0;
    end else begin
      // a beat leaving the output register; S_DONE refills it itself
      if (out_valid && !out_stall && state != S_DONE) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_CLEAR: begin
          clr_cnt <= clr_cnt + 1'b1;
          if (clr_cnt == LAST_SLOT) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept) begin
            cmd_r <= command;
            key_r <= key;
            state <= S_HASH;
          end
        end
        S_HASH: begin
          if (hash_done) begin
            state <= S_LOOKUP;
          end
        end
        S_LOOKUP: begin
          hand       <= key_r;
          hand_slot  <= hash_s1;
          hand_other <= hash_s2;
          side       <= 1'b0;
          placed     <= '0;
          state      <= (cmd_r == CMD_ERASE) ? S_ERASE : S_PLACE;
        end
        S_PLACE: begin
          res_hit <= 1'b0;
          if (!cur_v) begin
            res_status  <= ST_INSERTED;
            res_dropped <= '0;
            state       <= S_DONE;
          end else if (last_place) begin
            res_status  <= ST_OVERFLOW;
            res_dropped <= cur_key;
            state       <= S_DONE;
          end else begin
            hand       <= cur_key;
            hand_slot  <= cur_oth;
            hand_other <= hand_slot;
            side       <= !side;
            placed     <= placed + 1'b1;
          end
        end
        S_ERASE: begin
          res_dropped <= '0;
          res_hit     <= !hit1 && hit2;
          res_status  <= (hit1 || hit2) ? ST_ERASED : ST_NOT_FOUND;
          state       <= S_DONE;
        end
        S_DONE: begin
          if (!out_valid || !out_stall) begin
            out_valid   <= 1'b1;
            out_status  <= res_status;
            dropped_key <= res_dropped;
            hit_table   <= res_hit;
            state       <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign status = out_status;

`ifndef SYNTH
  a_drop_only_on_overflow: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_status != ST_OVERFLOW) |-> dropped_key == '0)
    else $error("dropped_key nonzero without overflow");

  a_hit_only_on_erase: assert property (@(posedge clk) disable iff (rst)
    out_valid && hit_table |-> out_status == ST_ERASED)
    else $error("hit_table set on a result that is not an erase hit");

  a_dual_write_only_clear: assert property (@(posedge clk) disable iff (rst)
    we1 && we2 |-> state == S_CLEAR)
    else $error("both tables written outside the clearing pass");

  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    accept |=> in_stall)
    else $error("second command accepted while one is in flight");
`endif

endmodule

FILE: tb/tb_cuckoo_hash_table.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_cuckoo_hash_table
// Drives insert and erase beats into the two-table cuckoo hash set. A shadow
// copy of both tables, kept inside a small scoreboard class, predicts every
// result, and each output beat is checked field by field in order. Random
// idling and stalling on both channels, a long output hold-off that backs
// the block up, and a full drain before the run ends.
// ----------------------------------------------------------------------------
module tb_cuckoo_hash_table;
  import cht_pkg::*;

  localparam int TS         = TABLE_SIZE_DEF;
  localparam int CYCLE_CAP  = 500000;
  localparam int PHASE_BEATS = 570;

  typedef struct {
    status_t          status;
    logic [KEY_W-1:0] dropped;
    logic             hit;
  } hash_result_t;

  // Shadow of both tables plus the queue of results still owed by the block.
  class cuckoo_shadow #(int SIZE = 8);
    logic [KEY_W-1:0] t1_key[SIZE];
    bit               t1_valid[SIZE];
    logic [KEY_W-1:0] t2_key[SIZE];
    bit               t2_valid[SIZE];
    hash_result_t     owed[$];
    int               errors;

    function new();
      foreach (t1_valid[i]) begin
        t1_valid[i] = 1'b0;
        t2_valid[i] = 1'b0;
        t1_key[i]   = '0;
        t2_key[i]   = '0;
      end
      errors = 0;
    endfunction

    function int slot_one(logic [KEY_W-1:0] k);
      return int'(k % SIZE);
    endfunction

    function int slot_two(logic [KEY_W-1:0] k);
      return int'((k / SIZE) % SIZE);
    endfunction

    function int pending();
      return owed.size();
    endfunction

    // Apply one accepted command to the shadow tables and queue its result.
    function void note_command(logic cmd, logic [KEY_W-1:0] k);
      hash_result_t     r;
      logic [KEY_W-1:0] hand;
      logic [KEY_W-1:0] old;
      bit               side;
      bit               holding;
      int               placed;
      int               s;
      int               s2;
      r.status  = ST_INSERTED;
      r.dropped = '0;
      r.hit     = 1'b0;
      if (cmd == CMD_INSERT) begin
        hand    = k;
        side    = 1'b0;
        holding = 1'b1;
        placed  = 0;
        // kick the occupant to the other table, at most SIZE placements
        while (holding && placed < SIZE) begin
          if (!side) begin
            s = slot_one(hand);
            if (!t1_valid[s]) begin
              t1_key[s]   = hand;
              t1_valid[s] = 1'b1;
              holding     = 1'b0;
            end else begin
              old       = t1_key[s];
              t1_key[s] = hand;
              hand      = old;
            end
          end else begin
            s = slot_two(hand);
            if (!t2_valid[s]) begin
              t2_key[s]   = hand;
              t2_valid[s] = 1'b1;
              holding     = 1'b0;
            end else begin
              old       = t2_key[s];
              t2_key[s] = hand;
              hand      = old;
            end
          end
          side = !side;
          placed++;
        end
        if (holding) begin
          r.status  = ST_OVERFLOW;
          r.dropped = hand;
        end
      end else begin
        s  = slot_one(k);
        s2 = slot_two(k);
        if (t1_valid[s] && t1_key[s] == k) begin
          t1_valid[s] = 1'b0;
          r.status    = ST_ERASED;
        end else if (t2_valid[s2] && t2_key[s2] == k) begin
          t2_valid[s2] = 1'b0;
          r.status     = ST_ERASED;
          r.hit        = 1'b1;
        end else begin
          r.status = ST_NOT_FOUND;
        end
      end
      owed.push_back(r);
    endfunction

    function void check_result(logic [1:0] st, logic [KEY_W-1:0] dk, logic ht);
      hash_result_t r;
      if (owed.size() == 0) begin
        errors++;
        if (errors <= 40)
          $display("%0t: unexpected result beat, expected none, got status %0d", $time, st);
        return;
      end
      r = owed.pop_front();
      if (st !== r.status) begin
        errors++;
        if (errors <= 40)
          $display("%0t: status expected %0d got %0d", $time, r.status, st);
      end
      if (dk !== r.dropped) begin
        errors++;
        if (errors <= 40)
          $display("%0t: dropped_key expected %h got %h", $time, r.dropped, dk);
      end
      if (ht !== r.hit) begin
        errors++;
        if (errors <= 40)
          $display("%0t: hit_table expected %0d got %0d", $time, r.hit, ht);
      end
    endfunction
  endclass

  logic             clk       = 1'b0;
  logic             rst       = 1'b1;
  logic             in_valid  = 1'b0;
  logic             in_stall;
  logic             command   = CMD_INSERT;
  logic [KEY_W-1:0] key       = '0;
  logic             out_valid;
  logic             out_stall = 1'b0;
  logic [1:0]       status;
  logic [KEY_W-1:0] dropped_key;
  logic             hit_table;

  cuckoo_shadow #(TS) shadow;

  int send_gap_pct   = 0;
  int recv_stall_pct = 0;
  logic hold_go      = 1'b0;   // pulsed by the stimulus to start a long hold-off
  logic hold_go_q    = 1'b0;
  int hold_left      = 0;
  int cycles         = 0;

  // keys believed to be stored, used to aim erases and duplicate inserts
  logic [KEY_W-1:0] live_keys[$];

  cuckoo_hash_table #(.TABLE_SIZE(TS)) uut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .command     (command),
    .key         (key),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .status      (status),
    .dropped_key (dropped_key),
    .hit_table   (hit_table)
  );

  always #4 clk = ~clk;

  // Output side: random stall, or a long hold-off counted here once asked for.
  // Every beat taken is handed to the scoreboard.
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall)
      shadow.check_result(status, dropped_key, hit_table);
    hold_go_q <= hold_go;
    if (hold_go && !hold_go_q)
      hold_left = 300;
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // Hard stop in case the block hangs.
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_CAP) begin
      $display("Timeout after %0d cycles", cycles);
      $display("Mismatches found");
      $finish;
    end
  end

  // One command beat: optional idle cycles, then hold the beat until taken.
  task automatic send_beat(input logic cmd, input logic [KEY_W-1:0] k);
    while ($urandom_range(99) < send_gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    command  <= cmd;
    key      <= k;
    do @(posedge clk); while (in_stall);
    shadow.note_command(cmd, k);
  endtask

  // Drop valid and wait until every owed result is back.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (shadow.pending() != 0) @(posedge clk);
  endtask

  // Mostly tracked keys so erases hit and slots collide; some noise on top.
  task automatic send_random_beat();
    logic [KEY_W-1:0] k;
    int               pick;
    int               idx;
    pick = $urandom_range(99);
    if (live_keys.size() > 0 && pick < 40) begin
      idx = $urandom_range(live_keys.size() - 1);
      k   = live_keys[idx];
      live_keys.delete(idx);
      send_beat(CMD_ERASE, k);
    end else if (pick < 48) begin
      send_beat(CMD_ERASE, KEY_W'($urandom));
    end else if (live_keys.size() > 0 && pick < 58) begin
      k = live_keys[$urandom_range(live_keys.size() - 1)];
      send_beat(CMD_INSERT, k);   // duplicate
    end else begin
      if ($urandom_range(3) == 0)
        k = KEY_W'($urandom_range(255));
      else
        k = KEY_W'($urandom);
      live_keys.push_back(k);
      if (live_keys.size() > 24)
        void'(live_keys.pop_front());
      send_beat(CMD_INSERT, k);
    end
  endtask

  initial begin
    shadow = new();
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Directed part. With 8 slots, table one uses key[2:0] and table two
    // key[5:3]; multiples of 64 all land in slot 0 of both tables.
    send_gap_pct   = 0;
    recv_stall_pct = 0;
    send_beat(CMD_ERASE,  31'd0);            // empty table, not found
    send_beat(CMD_INSERT, 31'd0);
    send_beat(CMD_INSERT, 31'd0);            // duplicate pushes first copy to table two
    send_beat(CMD_ERASE,  31'd0);            // hit in table one
    send_beat(CMD_ERASE,  31'd0);            // hit in table two
    send_beat(CMD_ERASE,  31'd0);            // both copies gone
    send_beat(CMD_INSERT, 31'h7FFF_FFFF);
    send_beat(CMD_INSERT, 31'h7FFF_FFF7);    // same table-one slot, kicks the first
    send_beat(CMD_ERASE,  31'h7FFF_FFFF);    // found in table two
    send_beat(CMD_ERASE,  31'h7FFF_FFF7);
    send_beat(CMD_INSERT, 31'd64);
    send_beat(CMD_INSERT, 31'd128);
    send_beat(CMD_INSERT, 31'd192);          // cycle of kicks, overflow drops an occupant
    send_beat(CMD_ERASE,  31'd8);            // occupied slot, different key
    send_beat(CMD_ERASE,  31'd64);
    send_beat(CMD_ERASE,  31'd128);
    send_beat(CMD_ERASE,  31'd192);
    send_beat(CMD_INSERT, 31'h5555_5555);
    send_beat(CMD_INSERT, 31'h2AAA_AAAA);
    send_beat(CMD_ERASE,  31'h5555_5555);
    send_beat(CMD_ERASE,  31'h2AAA_AAAA);
    drain();

    // Phase one: sender idles less than the receiver stalls.
    send_gap_pct   = 37;
    recv_stall_pct = 62;
    for (int i = 0; i < PHASE_BEATS; i++) begin
      if (i == PHASE_BEATS / 2) begin
        // long output hold-off while the sender keeps offering beats
        send_gap_pct = 0;
        hold_go <= 1'b1;
        send_random_beat();
        hold_go <= 1'b0;
        for (int j = 0; j < 19; j++) send_random_beat();
        send_gap_pct = 37;
      end
      send_random_beat();
    end
    drain();

    // Phase two: roles swapped.
    send_gap_pct   = 62;
    recv_stall_pct = 37;
    for (int i = 0; i < PHASE_BEATS; i++) send_random_beat();
    drain();   // sender waits for every owed result before going on

    // Phase three: back to back on both sides.
    send_gap_pct   = 0;
    recv_stall_pct = 0;
    for (int i = 0; i < PHASE_BEATS; i++) send_random_beat();
    drain();
    repeat (40) @(posedge clk);

    if (shadow.errors == 0 && shadow.pending() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

FILE: sim.f
rtl/core/cht_pkg.sv
rtl/core/cht_ram.sv
rtl/core/cuckoo_hash_table.sv
tb/tb_cuckoo_hash_table.sv
